// ===== rtl/hllru_pkg.sv =====
// shared types, codes and constants of the hyperloglog register update unit
package hllru_pkg;

  localparam int MAX_PRECISION_DEF = 14;
  localparam int PREC_RESET        = 14;
  localparam int MIN_PREC          = 4;
  localparam int RANK_W            = 6;
  localparam int HASH_W            = 64;
  localparam int SEL_W             = 14;
  localparam int ZCOUNT_W          = 15;
  localparam int QUEUE_DEPTH       = 2;
  localparam int CFG_ADDR_W        = 2;
  localparam int CFG_DATA_W        = 32;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_MERGE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] ADDR_PRECISION = '0;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [HASH_W-1:0] hash_value;
    logic [SEL_W-1:0]  reg_select;
    logic [RANK_W-1:0] merge_rank;
  } in_item_t;

  typedef struct packed {
    logic [SEL_W-1:0]    target_index;
    logic [RANK_W-1:0]   old_rank;
    logic [RANK_W-1:0]   stored_rank;
    logic                raised;
    logic [ZCOUNT_W-1:0] zero_registers;
  } out_item_t;

endpackage

// ===== rtl/hllru_front.sv =====
// front end: decodes a transaction into register index, rank and update flag
module hllru_front import hllru_pkg::*; #(
  parameter int IDX_W  = MAX_PRECISION_DEF,
  parameter int PREC_W = 4
) (
  input  in_item_t                  item,
  input  logic [PREC_W-1:0]         precision,
  output logic [IDX_W+RANK_W:0]     entry
);

  localparam int SELX_W = IDX_W + SEL_W;

  logic [HASH_W-1:0] forced;
  logic [IDX_W-1:0]  idx_mask;
  logic [HASH_W-1:0] shifted;
  logic [SELX_W-1:0] sel_wide;
  logic [7:0]        grp_nz;
  logic [2:0]        grp_tz [8];
  logic [5:0]        tz;
  logic [RANK_W-1:0] run_rank;
  logic [IDX_W-1:0]  idx;
  logic [RANK_W-1:0] rank;
  logic              modify;

  // top precision bits forced to ones so the zero run always ends
  always_comb begin
    for (int i = 0; i < HASH_W; i++) begin
      forced[i] = item.hash_value[i] | ((7'(i) + 7'(precision)) >= 7'd64);
    end
  end

  // trailing zero count: per byte, then first non-empty byte
  always_comb begin
    for (int g = 0; g < 8; g++) begin
      grp_nz[g] = |forced[8*g +: 8];
      grp_tz[g] = 3'd0;
      for (int b = 7; b >= 0; b--) begin
        if (forced[8*g + b]) grp_tz[g] = 3'(b);
      end
    end
    tz = 6'd0;
    for (int g = 7; g >= 0; g--) begin
      if (grp_nz[g]) tz = {3'(g), grp_tz[g]};
    end
  end

  assign run_rank  = tz + 6'd1;
  assign idx_mask  = ~({IDX_W{1'b1}} << precision);
  assign shifted   = item.hash_value >> (7'd64 - 7'(precision));
  assign sel_wide  = SELX_W'(item.reg_select);

  always_comb begin
    unique case (item.opcode)
      OP_ADD: begin
        idx    = shifted[IDX_W-1:0] & idx_mask;
        rank   = run_rank;
        modify = 1'b1;
      end
      OP_MERGE: begin
        idx    = sel_wide[IDX_W-1:0] & idx_mask;
        rank   = item.merge_rank;
        modify = 1'b1;
      end
      OP_READ, OP_RSVD: begin
        idx    = sel_wide[IDX_W-1:0] & idx_mask;
        rank   = '0;
        modify = 1'b0;
      end
      default: begin
        idx    = '0;
        rank   = '0;
        modify = 1'b0;
      end
    endcase
  end

  assign entry = {modify, rank, idx};

endmodule

// ===== rtl/hllru_queue.sv =====
// short queue between front and back end
module hllru_queue import hllru_pkg::*; #(
  parameter int WIDTH = 21
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             valid,
  output logic [WIDTH-1:0] head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== rtl/hllru_back.sv =====
// back end: register store, read-modify-write, zero count and clearing sweep
module hllru_back import hllru_pkg::*; #(
  parameter int IDX_W  = MAX_PRECISION_DEF,
  parameter int PREC_W = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clear_req,
  input  logic [PREC_W-1:0]     precision,
  input  logic                  q_valid,
  input  logic [IDX_W+RANK_W:0] q_entry,
  output logic                  pop,
  output logic                  clearing,
  output logic                  out_valid,
  output out_item_t             out_data
);

  localparam int MEM_DEPTH = 1 << IDX_W;
  localparam int CNT_W     = IDX_W + 1;
  localparam int IDXX_W    = IDX_W + SEL_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_UPD   = 2'd2;

  logic [RANK_W-1:0]     store_mem [MEM_DEPTH];
  logic [1:0]            state_r, state_nxt;
  logic [IDX_W-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0]      empty_r, empty_nxt;
  logic [IDX_W+RANK_W:0] item_r, item_nxt;
  logic [RANK_W-1:0]     rdata_r;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [RANK_W-1:0]     mem_wdata;
  logic [IDX_W-1:0]      item_idx;
  logic [RANK_W-1:0]     item_rank;
  logic                  item_modify;
  logic                  raise;
  logic [IDXX_W-1:0]     idx_wide;

  assign item_idx    = item_r[IDX_W-1:0];
  assign item_rank   = item_r[IDX_W +: RANK_W];
  assign item_modify = item_r[IDX_W+RANK_W];
  assign raise       = item_modify && (rdata_r < item_rank);
  assign idx_wide    = IDXX_W'(item_idx);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    empty_nxt     = empty_r;
    item_nxt      = item_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_cnt_r;
    mem_wdata     = '0;
    pop           = 1'b0;
    if (clear_req) begin
      state_nxt   = ST_CLEAR;
      clr_cnt_nxt = '0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          mem_we      = 1'b1;
          empty_nxt   = CNT_W'(1) << precision;
          clr_cnt_nxt = clr_cnt_r + 1'b1;
          if (&clr_cnt_r) state_nxt = ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid) begin
            pop       = 1'b1;
            item_nxt  = q_entry;
            state_nxt = ST_UPD;
          end
        end
        ST_UPD: begin
          if (raise) begin
            mem_we    = 1'b1;
            mem_waddr = item_idx;
            mem_wdata = item_rank;
            if (rdata_r == '0 && empty_r != '0) empty_nxt = empty_r - 1'b1;
          end
          out_valid_nxt          = 1'b1;
          out_nxt.target_index   = idx_wide[SEL_W-1:0];
          out_nxt.old_rank       = rdata_r;
          out_nxt.stored_rank    = raise ? item_rank : rdata_r;
          out_nxt.raised         = raise;
          out_nxt.zero_registers = ZCOUNT_W'(empty_nxt);
          state_nxt              = ST_IDLE;
        end
        default: begin
          state_nxt   = ST_CLEAR;
          clr_cnt_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    empty_r <= empty_nxt;
    item_r  <= item_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_waddr] <= mem_wdata;
    if (pop) rdata_r <= store_mem[q_entry[IDX_W-1:0]];
  end

  assign clearing  = (state_r == ST_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_UPD))
    else $error("result without a preceding update cycle");

  a_raise_increases: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.raised) |-> (out_r.stored_rank > out_r.old_rank))
    else $error("raised flag with no increase");

  a_no_raise_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.raised) |-> (out_r.stored_rank == out_r.old_rank))
    else $error("register changed without raised flag");

  a_zero_count_falls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && !clear_req) |=> (empty_r <= $past(empty_r)))
    else $error("zero register count grew outside a clear");
`endif

endmodule

// ===== rtl/hyperloglog_register_update_unit.sv =====
// top level of the hyperloglog dense register update unit
//
// channel   direction  handshake                      payload
// in_       in         start high, busy low           in_data  (in_item_t)
// out_      out        out_valid, one cycle, no stall out_data (out_item_t)
// config    in/out     psel/penable/pwrite, pready=1  precision at byte address 0
//
// an accepted transaction is decoded in the front end and queued; the back end
// pops it, reads the store, then writes back and registers the result; it
// pops a new transaction only after the write-back of the last one, since each
// transaction reads the store and then writes it
// after reset and after every precision write the store is swept clear, one
// entry per cycle, through all 2^MAX_PRECISION entries with busy high
// busy is also high while the two-entry queue is full; the receiver never stalls
module hyperloglog_register_update_unit import hllru_pkg::*; #(
  parameter int MAX_PRECISION = MAX_PRECISION_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  output out_item_t             out_data,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W   = MAX_PRECISION;
  localparam int PREC_W  = $clog2(MAX_PRECISION + 1);
  localparam int ENTRY_W = IDX_W + RANK_W + 1;
  localparam int PREC_RESET_V = (PREC_RESET > MAX_PRECISION) ? MAX_PRECISION : PREC_RESET;

  logic [PREC_W-1:0]  precision_r, precision_nxt;
  logic               cfg_write;
  logic [3:0]         wr_val;
  logic               accept;
  logic [ENTRY_W-1:0] front_entry;
  logic               q_full;
  logic               q_valid;
  logic [ENTRY_W-1:0] q_head;
  logic               q_pop;
  logic               clearing;

  // precision write: clamp into range and start a fresh store
  assign cfg_write = psel && penable && pwrite && (paddr == ADDR_PRECISION);
  assign wr_val    = pwdata[3:0];

  // compare the low four written bits before narrowing to the precision field
  always_comb begin
    precision_nxt = precision_r;
    if (cfg_write) begin
      priority if (wr_val < 4'(MIN_PREC)) begin
        precision_nxt = PREC_W'(MIN_PREC);
      end else if ({1'b0, wr_val} > 5'(MAX_PRECISION)) begin
        precision_nxt = PREC_W'(MAX_PRECISION);
      end else begin
        precision_nxt = PREC_W'(wr_val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      precision_r <= PREC_W'(PREC_RESET_V);
    end else begin
      precision_r <= precision_nxt;
    end
  end

  assign prdata = CFG_DATA_W'(precision_r);
  assign pready = 1'b1;

  // transaction accepted while the queue has room and no sweep runs
  assign busy   = clearing || q_full;
  assign accept = start && !busy;

  hllru_front #(
    .IDX_W  (IDX_W),
    .PREC_W (PREC_W)
  ) u_front (
    .item      (in_data),
    .precision (precision_r),
    .entry     (front_entry)
  );

  hllru_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (front_entry),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  // the sweep picks up the new precision in the cycle after the write
  hllru_back #(
    .IDX_W  (IDX_W),
    .PREC_W (PREC_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear_req (cfg_write),
    .precision (precision_r),
    .q_valid   (q_valid),
    .q_entry   (q_head),
    .pop       (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
